### hw/rtl/i2p_pkg.sv
// Shared types, constants and helper functions for the infix-to-postfix converter.
package i2p_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// stack entry codes
	typedef logic [2:0] code_t;
	localparam code_t CODE_ADD    = 3'd0;
	localparam code_t CODE_SUB    = 3'd1;
	localparam code_t CODE_MUL    = 3'd2;
	localparam code_t CODE_DIV    = 3'd3;
	localparam code_t CODE_PAREN  = 3'd4;
	localparam code_t CODE_SQUARE = 3'd5;
	localparam code_t CODE_CURLY  = 3'd6;

	// ASCII characters of interest
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LSQ    = 8'h5B;
	localparam logic [7:0] CH_RSQ    = 8'h5D;
	localparam logic [7:0] CH_LCURLY = 8'h7B;
	localparam logic [7:0] CH_RCURLY = 8'h7D;
	localparam logic [7:0] CH_DIG_LO = 8'h30;
	localparam logic [7:0] CH_DIG_HI = 8'h39;
	localparam logic [7:0] CH_UC_LO  = 8'h41;
	localparam logic [7:0] CH_UC_HI  = 8'h5A;
	localparam logic [7:0] CH_LC_LO  = 8'h61;
	localparam logic [7:0] CH_LC_HI  = 8'h7A;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_ALNUM,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OPER
	} char_cls_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RB_RD,
		ST_RB_CHK,
		ST_OP_RD,
		ST_OP_CHK,
		ST_FL_RD,
		ST_FL_CHK,
		ST_FIN
	} state_t;

	// entry carries its own code and the code of the next bracket below it
	typedef struct packed {
		code_t code;
		code_t below_br;
	} stk_entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		stk_entry_t        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} stk_req_t;

	function automatic char_cls_t char_cls(input logic [7:0] ch);
		char_cls_t cls;
		cls = CLS_OTHER;
		if ((ch >= CH_DIG_LO && ch <= CH_DIG_HI) || (ch >= CH_UC_LO && ch <= CH_UC_HI) ||
		    (ch >= CH_LC_LO && ch <= CH_LC_HI)) begin
			cls = CLS_ALNUM;
		end else begin
			case (ch)
				CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: cls = CLS_OPER;
				CH_LPAREN, CH_LSQ, CH_LCURLY:         cls = CLS_OPEN;
				CH_RPAREN, CH_RSQ, CH_RCURLY:         cls = CLS_CLOSE;
				default:                              cls = CLS_OTHER;
			endcase
		end
		return cls;
	endfunction

	// closing brackets map onto the code of their opening partner
	function automatic code_t code_of(input logic [7:0] ch);
		code_t c;
		case (ch)
			CH_PLUS:              c = CODE_ADD;
			CH_MINUS:             c = CODE_SUB;
			CH_STAR:              c = CODE_MUL;
			CH_SLASH:             c = CODE_DIV;
			CH_LPAREN, CH_RPAREN: c = CODE_PAREN;
			CH_LSQ, CH_RSQ:       c = CODE_SQUARE;
			default:              c = CODE_CURLY;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] op_char(input code_t c);
		logic [7:0] ch;
		case (c)
			CODE_ADD: ch = CH_PLUS;
			CODE_SUB: ch = CH_MINUS;
			CODE_MUL: ch = CH_STAR;
			default:  ch = CH_SLASH;
		endcase
		return ch;
	endfunction

	function automatic logic [1:0] prec_of(input code_t c);
		logic [1:0] p;
		case (c)
			CODE_ADD, CODE_SUB: p = 2'd1;
			CODE_MUL, CODE_DIV: p = 2'd2;
			default:            p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

### hw/rtl/i2p_stack_ram.sv
// Operator stack storage: one write port, one read port, registered read data.
module i2p_stack_ram (
	input  logic                clk,
	input  i2p_pkg::stk_req_t   req,
	output i2p_pkg::stk_entry_t rdata
);

	i2p_pkg::stk_entry_t mem [i2p_pkg::STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

### hw/rtl/infix_to_postfix_converter_unit.sv
// Top level of the infix-to-postfix converter: control, stack pointer, flags, output stage.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata = char_in, s_tlast = is_last
//  m_*     | out | m_tvalid/m_tready  | m_tdata = char_out, m_tlast = run_end,
//          |     |                    | m_tuser = has_char, expr_done, unbalanced, overflowed
//
// Flow: one character at a time. A letter or digit passes through the end state; a left
// bracket or an ignored byte returns straight to idle. A right bracket or an operator reads
// stack entries one by one (the stack sits in a memory with registered read data, so each
// entry is a read followed by a check) until one stops the pop loop or the stack runs empty.
// The last character then drains the stack the same way, dropping left brackets, and ends
// in the end state.
// A result waits in a one-deep hold register until the next one is known, so run_end is exact;
// a second output register lets the next item be accepted while the last result waits.
// Reset clears the stack pointer, bracket count, flags and both valid bits; the stack memory
// itself is never cleared. A stall on m_tready holds the pop loop in its check state and the
// end state until the output register frees.
module infix_to_postfix_converter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // is_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] char_out
	output logic       m_tlast,   // run_end
	output logic [3:0] m_tuser    // [0] has_char, [1] expr_done, [2] unbalanced, [3] overflowed
);

	localparam logic [i2p_pkg::CNT_W-1:0] DEPTH_C = i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH);
	localparam logic [i2p_pkg::CNT_W-1:0] ONE_C   = i2p_pkg::CNT_W'(1);
	localparam logic [i2p_pkg::CNT_W-1:0] ZERO_C  = '0;

	i2p_pkg::state_t state_q, state_d;

	// stack bookkeeping
	logic [i2p_pkg::CNT_W-1:0] cnt_q;
	logic [i2p_pkg::CNT_W-1:0] br_cnt_q;
	i2p_pkg::code_t            top_br_q;   // code of topmost bracket, valid when br_cnt_q != 0
	i2p_pkg::code_t            cur_code_q; // operator or wanted bracket of the current item
	logic                      last_q;
	logic                      mis_q;
	logic                      ovf_q;

	// one-deep hold register for the newest result of the current item
	logic       pend_valid_q;
	logic [7:0] pend_char_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic [3:0] out_user_q;

	// memory interface
	i2p_pkg::stk_req_t   ram_req;
	i2p_pkg::stk_entry_t ram_rdata;

	// control from the next-state logic
	logic           new_res;
	logic [7:0]     new_char;
	logic           push_en;
	i2p_pkg::code_t push_code;
	logic           pop_en;
	logic           pop_br;
	logic           rd_en;
	logic           fin_out;
	logic           fin_clear;
	logic           mis_set;
	logic           ovf_set;

	logic                      out_free;
	logic                      stall_emit;
	logic                      push_ok;
	logic [i2p_pkg::CNT_W-1:0] cnt_m1;
	i2p_pkg::char_cls_t        in_cls;
	i2p_pkg::code_t            in_code;
	logic                      top_is_op;

	i2p_stack_ram u_stack (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	assign out_free   = !out_valid_q || m_tready;
	assign stall_emit = pend_valid_q && !out_free;
	assign cnt_m1     = cnt_q - ONE_C;
	assign in_cls     = i2p_pkg::char_cls(s_tdata);
	assign in_code    = i2p_pkg::code_of(s_tdata);
	assign top_is_op  = !ram_rdata.code[2];
	assign push_ok    = push_en && (cnt_q != DEPTH_C);
	assign s_tready   = (state_q == i2p_pkg::ST_IDLE);

	assign ram_req.we       = push_ok;
	assign ram_req.waddr    = cnt_q[i2p_pkg::ADDR_W-1:0];
	assign ram_req.wdata    = '{code: push_code, below_br: top_br_q};
	assign ram_req.re       = rd_en;
	assign ram_req.raddr    = cnt_m1[i2p_pkg::ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2p_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and per-cycle actions
	always_comb begin
		state_d   = state_q;
		new_res   = 1'b0;
		new_char  = i2p_pkg::CH_NUL;
		push_en   = 1'b0;
		push_code = cur_code_q;
		pop_en    = 1'b0;
		pop_br    = 1'b0;
		rd_en     = 1'b0;
		fin_out   = 1'b0;
		fin_clear = 1'b0;
		mis_set   = 1'b0;
		ovf_set   = 1'b0;
		case (state_q)
			i2p_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					// the final mismatch state is known here, before any result leaves
					case (in_cls)
						i2p_pkg::CLS_ALNUM: begin
							new_res  = 1'b1;
							new_char = s_tdata;
							mis_set  = s_tlast && (br_cnt_q != ZERO_C);
							state_d  = s_tlast ? i2p_pkg::ST_FL_RD : i2p_pkg::ST_FIN;
						end
						i2p_pkg::CLS_OPEN: begin
							push_en   = 1'b1;
							push_code = in_code;
							ovf_set   = (cnt_q == DEPTH_C);
							mis_set   = s_tlast && ((br_cnt_q != ZERO_C) || (cnt_q != DEPTH_C));
							state_d   = s_tlast ? i2p_pkg::ST_FL_RD : i2p_pkg::ST_IDLE;
						end
						i2p_pkg::CLS_CLOSE: begin
							mis_set = (br_cnt_q == ZERO_C) || (top_br_q != in_code) ||
							          (s_tlast && (br_cnt_q > ONE_C));
							state_d = i2p_pkg::ST_RB_RD;
						end
						i2p_pkg::CLS_OPER: begin
							mis_set = s_tlast && (br_cnt_q != ZERO_C);
							state_d = i2p_pkg::ST_OP_RD;
						end
						default: begin
							mis_set = s_tlast && (br_cnt_q != ZERO_C);
							state_d = s_tlast ? i2p_pkg::ST_FL_RD : i2p_pkg::ST_IDLE;
						end
					endcase
				end
			end
			i2p_pkg::ST_RB_RD: begin
				if (cnt_q == ZERO_C) begin
					state_d = last_q ? i2p_pkg::ST_FL_RD : i2p_pkg::ST_FIN;
				end else begin
					rd_en   = 1'b1;
					state_d = i2p_pkg::ST_RB_CHK;
				end
			end
			i2p_pkg::ST_RB_CHK: begin
				if (top_is_op) begin
					if (!stall_emit) begin
						new_res  = 1'b1;
						new_char = i2p_pkg::op_char(ram_rdata.code);
						pop_en   = 1'b1;
						state_d  = i2p_pkg::ST_RB_RD;
					end
				end else begin
					pop_en  = 1'b1;
					pop_br  = 1'b1;
					state_d = last_q ? i2p_pkg::ST_FL_RD : i2p_pkg::ST_FIN;
				end
			end
			i2p_pkg::ST_OP_RD: begin
				if (cnt_q == ZERO_C) begin
					push_en = 1'b1;
					state_d = last_q ? i2p_pkg::ST_FL_RD : i2p_pkg::ST_FIN;
				end else begin
					rd_en   = 1'b1;
					state_d = i2p_pkg::ST_OP_CHK;
				end
			end
			i2p_pkg::ST_OP_CHK: begin
				if (top_is_op &&
				    (i2p_pkg::prec_of(ram_rdata.code) >= i2p_pkg::prec_of(cur_code_q))) begin
					if (!stall_emit) begin
						new_res  = 1'b1;
						new_char = i2p_pkg::op_char(ram_rdata.code);
						pop_en   = 1'b1;
						state_d  = i2p_pkg::ST_OP_RD;
					end
				end else begin
					// a full stack here means nothing was popped, so no result carries stale flags
					push_en = 1'b1;
					ovf_set = (cnt_q == DEPTH_C);
					state_d = last_q ? i2p_pkg::ST_FL_RD : i2p_pkg::ST_FIN;
				end
			end
			i2p_pkg::ST_FL_RD: begin
				if (cnt_q == ZERO_C) begin
					state_d = i2p_pkg::ST_FIN;
				end else begin
					rd_en   = 1'b1;
					state_d = i2p_pkg::ST_FL_CHK;
				end
			end
			i2p_pkg::ST_FL_CHK: begin
				if (top_is_op) begin
					if (!stall_emit) begin
						new_res  = 1'b1;
						new_char = i2p_pkg::op_char(ram_rdata.code);
						pop_en   = 1'b1;
						state_d  = i2p_pkg::ST_FL_RD;
					end
				end else begin
					// drop a leftover left bracket; the mismatch was flagged on accept
					pop_en  = 1'b1;
					pop_br  = 1'b1;
					state_d = i2p_pkg::ST_FL_RD;
				end
			end
			i2p_pkg::ST_FIN: begin
				if (pend_valid_q || last_q) begin
					if (out_free) begin
						fin_out   = 1'b1;
						fin_clear = last_q;
						state_d   = i2p_pkg::ST_IDLE;
					end
				end else begin
					state_d = i2p_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = i2p_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			br_cnt_q     <= '0;
			mis_q        <= 1'b0;
			ovf_q        <= 1'b0;
			last_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin_clear) begin
				cnt_q    <= '0;
				br_cnt_q <= '0;
				mis_q    <= 1'b0;
				ovf_q    <= 1'b0;
			end else begin
				if (push_ok) begin
					cnt_q <= cnt_q + ONE_C;
				end else if (pop_en) begin
					cnt_q <= cnt_m1;
				end
				if (push_ok && push_code[2]) begin
					br_cnt_q <= br_cnt_q + ONE_C;
				end else if (pop_br) begin
					br_cnt_q <= br_cnt_q - ONE_C;
				end
				if (mis_set) begin
					mis_q <= 1'b1;
				end
				if (ovf_set) begin
					ovf_q <= 1'b1;
				end
			end
			if (s_tvalid && s_tready) begin
				last_q <= s_tlast;
			end
			if (new_res) begin
				pend_valid_q <= 1'b1;
			end else if (fin_out) begin
				pend_valid_q <= 1'b0;
			end
			if ((new_res && pend_valid_q) || fin_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cur_code_q <= in_code;
		end
		if (push_ok && push_code[2]) begin
			top_br_q <= push_code;
		end else if (pop_br) begin
			top_br_q <= ram_rdata.below_br;
		end
		if (new_res) begin
			pend_char_q <= new_char;
		end
		// flags are final for the whole item by the time any of its results moves out
		if (new_res && pend_valid_q) begin
			out_char_q <= pend_char_q;
			out_last_q <= 1'b0;
			out_user_q <= {ovf_q, mis_q, 1'b0, 1'b1};
		end else if (fin_out) begin
			out_char_q <= pend_valid_q ? pend_char_q : i2p_pkg::CH_NUL;
			out_last_q <= 1'b1;
			out_user_q <= {ovf_q, mis_q, last_q, pend_valid_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("stack pointer beyond depth");

	a_br_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		br_cnt_q <= cnt_q)
		else $error("bracket count exceeds stack fill");

	a_hold_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(new_res && pend_valid_q) |-> out_free)
		else $error("held result overwritten while output stalled");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_valid_q)
		else $error("result left over from previous item");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin_clear |=> (cnt_q == ZERO_C) && (br_cnt_q == ZERO_C) && !mis_q && !ovf_q)
		else $error("expression end did not clear stack state");

endmodule
